[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define MAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/mau_pkg.sv]
// Types, constants and command codes of the modular arithmetic unit.
package mau_pkg;

    localparam int MOD_BITS = 31;
    localparam int OPW      = 64;
    localparam int CNT_W    = $clog2(OPW + 1);

    typedef logic [MOD_BITS-1:0] t_res;
    typedef logic [MOD_BITS:0]   t_wide;
    typedef logic [OPW-1:0]      t_word;
    typedef logic [CNT_W-1:0]    t_cnt;

    localparam t_res MOD_RESET = t_res'(998244353);

    typedef enum logic [3:0] {
        ACT_ADD    = 4'd0,
        ACT_SUB    = 4'd1,
        ACT_MUL    = 4'd2,
        ACT_DIV    = 4'd3,
        ACT_XOR    = 4'd4,
        ACT_POW    = 4'd5,
        ACT_NEG    = 4'd6,
        ACT_INV    = 4'd7,
        ACT_INC    = 4'd8,
        ACT_DEC    = 4'd9,
        ACT_REDUCE = 4'd10
    } t_action;

    typedef struct packed {
        logic [3:0]          action;
        logic signed [63:0]  operand_a;
        logic signed [63:0]  operand_b;
    } t_in;

    typedef struct packed {
        logic [MOD_BITS-1:0] result;
        logic                no_inverse;
    } t_out;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RED_A,
        CMD_RED_B,
        CMD_SET_A,
        CMD_SET_B,
        CMD_SIMPLE,
        CMD_XOR,
        CMD_MUL_AB,
        CMD_TAKE,
        CMD_POW_INIT,
        CMD_POW_MUL,
        CMD_POW_SQ,
        CMD_SET_BASE,
        CMD_EU_INIT,
        CMD_EU_DIV,
        CMD_EU_MUL,
        CMD_EU_UPD,
        CMD_EU_END,
        CMD_DIV_MUL,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic       busy;
        logic       exp_zero;
        logic       exp_lsb;
        logic       eb_zero;
        logic       fail;
        logic [3:0] action;
    } t_stat;

endpackage

[rtl/mau_datapath.sv]
// Datapath: operand registers, serial mod-multiply / divide unit, Euclid and power registers.
module mau_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mau_pkg::t_cmd    i_cmd,
    input  mau_pkg::t_in     i_in_data,
    input  logic             i_cfg_we,
    input  mau_pkg::t_res    i_cfg_data,
    output mau_pkg::t_stat   o_stat,
    output mau_pkg::t_out    o_out_data
);

    mau_pkg::t_res  r_mod, r_ra, r_rb, r_acc, r_base, r_ea, r_eb, r_eu, r_ev;
    mau_pkg::t_res  r_rem, r_x, r_dv;
    mau_pkg::t_res  n_mod, n_ra, n_rb, n_acc, n_base, n_ea, n_eb, n_eu, n_ev;
    mau_pkg::t_res  n_rem, n_x, n_dv;
    mau_pkg::t_word r_opa, r_opb, r_exp, r_str;
    mau_pkg::t_word n_opa, n_opb, n_exp, n_str;
    mau_pkg::t_cnt  r_cnt, n_cnt;
    logic [3:0]     r_act, n_act;
    logic           r_fail, n_fail, r_div, n_div;
    mau_pkg::t_out  r_out, n_out;

    mau_pkg::t_res  m_eff, one_mod, simple_res;
    mau_pkg::t_wide dvw, s_t1, s_t2, w_a, w_b, w_m, w_sum;
    logic           s_bit, s_q;

    // start request for the serial unit
    logic           st_go, st_div;
    mau_pkg::t_res  st_x, st_dv;
    mau_pkg::t_word st_str;
    mau_pkg::t_cnt  st_len;

    function automatic mau_pkg::t_word pre(input mau_pkg::t_res v);
        pre = {v, {(mau_pkg::OPW - mau_pkg::MOD_BITS){1'b0}}};
    endfunction

    function automatic mau_pkg::t_word mag(input mau_pkg::t_word v);
        mag = v[mau_pkg::OPW-1] ? (~v + mau_pkg::t_word'(1)) : v;
    endfunction

    assign m_eff   = (r_mod == '0) ? mau_pkg::t_res'(1) : r_mod;
    assign one_mod = (m_eff == mau_pkg::t_res'(1)) ? '0 : mau_pkg::t_res'(1);
    assign dvw     = {1'b0, r_dv};
    assign w_a     = {1'b0, r_ra};
    assign w_b     = {1'b0, r_rb};
    assign w_m     = {1'b0, m_eff};

    // one step: doubling mod dv plus optional addend, or one restoring divide step
    always_comb begin
        s_bit = r_str[mau_pkg::OPW-1];
        s_q   = 1'b0;
        s_t1  = {r_rem, 1'b0};
        s_t2  = '0;
        if (r_div) begin
            s_t1 = {r_rem, s_bit};
            s_q  = (s_t1 >= dvw);
            s_t2 = s_q ? (s_t1 - dvw) : s_t1;
        end else begin
            if (s_t1 >= dvw) s_t1 = s_t1 - dvw;
            s_t2 = s_t1 + (s_bit ? {1'b0, r_x} : '0);
            if (s_t2 >= dvw) s_t2 = s_t2 - dvw;
        end
    end

    always_comb begin
        w_sum      = w_a + w_b;
        simple_res = r_ra;
        case (r_act)
            mau_pkg::ACT_ADD: begin
                simple_res = (w_sum >= w_m) ? mau_pkg::t_res'(w_sum - w_m)
                                            : mau_pkg::t_res'(w_sum);
            end
            mau_pkg::ACT_SUB: begin
                simple_res = (r_ra >= r_rb) ? (r_ra - r_rb)
                                            : mau_pkg::t_res'(w_a + w_m - w_b);
            end
            mau_pkg::ACT_NEG: simple_res = (r_ra == '0) ? '0 : (m_eff - r_ra);
            mau_pkg::ACT_INC: begin
                simple_res = (w_a + 1'b1 >= w_m) ? mau_pkg::t_res'(w_a + 1'b1 - w_m)
                                                 : mau_pkg::t_res'(w_a + 1'b1);
            end
            mau_pkg::ACT_DEC: begin
                simple_res = (r_ra == '0) ? (m_eff - mau_pkg::t_res'(1))
                                          : (r_ra - mau_pkg::t_res'(1));
            end
            default: simple_res = r_ra;
        endcase
    end

    always_comb begin
        n_mod = r_mod;  n_ra = r_ra;   n_rb = r_rb;   n_acc = r_acc; n_base = r_base;
        n_ea  = r_ea;   n_eb = r_eb;   n_eu = r_eu;   n_ev = r_ev;
        n_rem = r_rem;  n_x  = r_x;    n_dv = r_dv;
        n_opa = r_opa;  n_opb = r_opb; n_exp = r_exp; n_str = r_str;
        n_cnt = r_cnt;  n_act = r_act; n_fail = r_fail; n_div = r_div; n_out = r_out;
        st_go = 1'b0;   st_div = 1'b0; st_x = mau_pkg::t_res'(1); st_dv = m_eff;
        st_str = '0;    st_len = mau_pkg::t_cnt'(mau_pkg::MOD_BITS);

        if (i_cfg_we) n_mod = i_cfg_data;

        case (i_cmd)
            mau_pkg::CMD_LOAD: begin
                n_act  = i_in_data.action;
                n_opa  = i_in_data.operand_a;
                n_opb  = i_in_data.operand_b;
                n_fail = 1'b0;
            end
            mau_pkg::CMD_RED_A: begin
                st_go  = 1'b1;
                st_str = mag(r_opa);
                st_len = mau_pkg::t_cnt'(mau_pkg::OPW);
            end
            mau_pkg::CMD_RED_B: begin
                st_go  = 1'b1;
                st_str = mag(r_opb);
                st_len = mau_pkg::t_cnt'(mau_pkg::OPW);
            end
            // wrap negatives upward
            mau_pkg::CMD_SET_A: begin
                n_ra = (r_opa[mau_pkg::OPW-1] && r_rem != '0) ? (m_eff - r_rem) : r_rem;
            end
            mau_pkg::CMD_SET_B: begin
                n_rb = (r_opb[mau_pkg::OPW-1] && r_rem != '0) ? (m_eff - r_rem) : r_rem;
            end
            mau_pkg::CMD_SIMPLE: n_acc = simple_res;
            mau_pkg::CMD_XOR: begin
                st_go  = 1'b1;
                st_str = pre(r_ra ^ r_rb);
            end
            mau_pkg::CMD_MUL_AB: begin
                st_go  = 1'b1;
                st_x   = r_ra;
                st_str = pre(r_rb);
            end
            mau_pkg::CMD_TAKE: n_acc = r_rem;
            mau_pkg::CMD_POW_INIT: begin
                n_acc  = one_mod;
                n_base = r_ra;
                n_exp  = r_opb[mau_pkg::OPW-1] ? '0 : r_opb;
            end
            mau_pkg::CMD_POW_MUL: begin
                st_go  = 1'b1;
                st_x   = r_acc;
                st_str = pre(r_base);
            end
            mau_pkg::CMD_POW_SQ: begin
                st_go  = 1'b1;
                st_x   = r_base;
                st_str = pre(r_base);
            end
            mau_pkg::CMD_SET_BASE: begin
                n_base = r_rem;
                n_exp  = r_exp >> 1;
            end
            mau_pkg::CMD_EU_INIT: begin
                n_ea = (r_act == mau_pkg::ACT_DIV) ? r_rb : r_ra;
                n_eb = m_eff;
                n_eu = one_mod;
                n_ev = '0;
            end
            mau_pkg::CMD_EU_DIV: begin
                st_go  = 1'b1;
                st_div = 1'b1;
                st_dv  = r_eb;
                st_str = pre(r_ea);
            end
            // quotient sits in the low bits of the stream; multiply it by v
            mau_pkg::CMD_EU_MUL: begin
                n_ea   = r_eb;
                n_eb   = r_rem;
                st_go  = 1'b1;
                st_x   = r_ev;
                st_str = pre(r_str[mau_pkg::MOD_BITS-1:0]);
            end
            mau_pkg::CMD_EU_UPD: begin
                n_eu = r_ev;
                n_ev = (r_eu >= r_rem) ? (r_eu - r_rem)
                                       : mau_pkg::t_res'({1'b0, r_eu} + w_m - {1'b0, r_rem});
            end
            mau_pkg::CMD_EU_END: begin
                n_fail = (r_ea != mau_pkg::t_res'(1)) && (m_eff != mau_pkg::t_res'(1));
                n_acc  = ((r_ea != mau_pkg::t_res'(1)) && (m_eff != mau_pkg::t_res'(1)))
                         ? '0 : r_eu;
            end
            mau_pkg::CMD_DIV_MUL: begin
                st_go  = 1'b1;
                st_x   = r_ra;
                st_str = pre(r_acc);
            end
            mau_pkg::CMD_OUT: begin
                n_out.result     = r_acc;
                n_out.no_inverse = r_fail;
            end
            default: ;
        endcase

        if (st_go) begin
            n_cnt = st_len;
            n_rem = '0;
            n_x   = st_x;
            n_dv  = st_dv;
            n_str = st_str;
            n_div = st_div;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - mau_pkg::t_cnt'(1);
            n_rem = mau_pkg::t_res'(s_t2);
            n_str = {r_str[mau_pkg::OPW-2:0], s_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mau_pkg::MOD_RESET;
            r_cnt <= '0;
        end else begin
            r_mod <= n_mod;
            r_cnt <= n_cnt;
        end
        r_ra  <= n_ra;  r_rb  <= n_rb;  r_acc <= n_acc; r_base <= n_base;
        r_ea  <= n_ea;  r_eb  <= n_eb;  r_eu  <= n_eu;  r_ev   <= n_ev;
        r_rem <= n_rem; r_x   <= n_x;   r_dv  <= n_dv;
        r_opa <= n_opa; r_opb <= n_opb; r_exp <= n_exp; r_str  <= n_str;
        r_act <= n_act; r_fail <= n_fail; r_div <= n_div; r_out <= n_out;
    end

    assign o_stat.busy     = (r_cnt != '0);
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];
    assign o_stat.eb_zero  = (r_eb == '0);
    assign o_stat.fail     = r_fail;
    assign o_stat.action   = r_act;
    assign o_out_data      = r_out;

endmodule

[rtl/mau_ctrl.sv]
// Controller: sequences reductions, power and Euclid loops, and the output register.
module mau_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic            o_cfg_ready,
    input  mau_pkg::t_stat  i_stat,
    output mau_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_RA, S_RA_W, S_RB, S_RB_W, S_OP, S_MUL_W,
        S_PW, S_PW_MUL_W, S_PW_SQ, S_PW_SQ_W,
        S_EU, S_EU_DIV_W, S_EU_MUL_W, S_EU_END, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = mau_pkg::CMD_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = mau_pkg::CMD_LOAD;
                    n_state = S_RA;
                end
            end
            S_RA: begin
                o_cmd   = mau_pkg::CMD_RED_A;
                n_state = S_RA_W;
            end
            S_RA_W: begin
                if (!i_stat.busy) begin
                    o_cmd   = mau_pkg::CMD_SET_A;
                    n_state = S_RB;
                end
            end
            S_RB: begin
                o_cmd   = mau_pkg::CMD_RED_B;
                n_state = S_RB_W;
            end
            S_RB_W: begin
                if (!i_stat.busy) begin
                    o_cmd   = mau_pkg::CMD_SET_B;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                case (i_stat.action)
                    mau_pkg::ACT_MUL: begin
                        o_cmd   = mau_pkg::CMD_MUL_AB;
                        n_state = S_MUL_W;
                    end
                    mau_pkg::ACT_XOR: begin
                        o_cmd   = mau_pkg::CMD_XOR;
                        n_state = S_MUL_W;
                    end
                    mau_pkg::ACT_POW: begin
                        o_cmd   = mau_pkg::CMD_POW_INIT;
                        n_state = S_PW;
                    end
                    mau_pkg::ACT_DIV, mau_pkg::ACT_INV: begin
                        o_cmd   = mau_pkg::CMD_EU_INIT;
                        n_state = S_EU;
                    end
                    default: begin
                        o_cmd   = mau_pkg::CMD_SIMPLE;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MUL_W: begin
                if (!i_stat.busy) begin
                    o_cmd   = mau_pkg::CMD_TAKE;
                    n_state = S_DONE;
                end
            end
            // square-and-multiply, exponent consumed from the low end
            S_PW: begin
                if (i_stat.exp_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.exp_lsb) begin
                    o_cmd   = mau_pkg::CMD_POW_MUL;
                    n_state = S_PW_MUL_W;
                end else begin
                    o_cmd   = mau_pkg::CMD_POW_SQ;
                    n_state = S_PW_SQ_W;
                end
            end
            S_PW_MUL_W: begin
                if (!i_stat.busy) begin
                    o_cmd   = mau_pkg::CMD_TAKE;
                    n_state = S_PW_SQ;
                end
            end
            S_PW_SQ: begin
                o_cmd   = mau_pkg::CMD_POW_SQ;
                n_state = S_PW_SQ_W;
            end
            S_PW_SQ_W: begin
                if (!i_stat.busy) begin
                    o_cmd   = mau_pkg::CMD_SET_BASE;
                    n_state = S_PW;
                end
            end
            S_EU: begin
                if (i_stat.eb_zero) begin
                    o_cmd   = mau_pkg::CMD_EU_END;
                    n_state = S_EU_END;
                end else begin
                    o_cmd   = mau_pkg::CMD_EU_DIV;
                    n_state = S_EU_DIV_W;
                end
            end
            S_EU_DIV_W: begin
                if (!i_stat.busy) begin
                    o_cmd   = mau_pkg::CMD_EU_MUL;
                    n_state = S_EU_MUL_W;
                end
            end
            S_EU_MUL_W: begin
                if (!i_stat.busy) begin
                    o_cmd   = mau_pkg::CMD_EU_UPD;
                    n_state = S_EU;
                end
            end
            S_EU_END: begin
                if (i_stat.action == mau_pkg::ACT_DIV && !i_stat.fail) begin
                    o_cmd   = mau_pkg::CMD_DIV_MUL;
                    n_state = S_MUL_W;
                end else begin
                    n_state = S_DONE;
                end
            end
            // hold until the output register is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd       = mau_pkg::CMD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid;

endmodule

[rtl/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit with a runtime modulus.
//
// Input channel: i_in_valid / o_in_stall carry one beat of action and two signed
// 64-bit operands. Output channel: o_out_valid / i_out_stall carry the residue
// and the no-inverse flag. Configuration: i_cfg_valid / o_cfg_ready write the
// modulus; ready is high only when no item is in flight and no result waits.
// One item is worked on at a time. Both operands are reduced by a bit-serial
// remainder unit, one after the other; the next beat can be taken as soon as
// the result is shown. Multiply and xor make one more pass through that unit;
// pow makes a squaring pass per exponent bit and a multiply pass for each set
// bit; div and inv make a divide and a multiply pass per Euclid step, and div
// one more multiply pass at the end. All of these passes share the one unit.
// Reset clears the controller, empties the output register and loads the
// modulus 998244353. A stalled result holds in the output register; the next
// input beat is still taken and worked on, and its result waits until the
// register is free.
module modular_arithmetic_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mau_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mau_pkg::t_out               o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mau_pkg::MOD_BITS-1:0] i_cfg_data
);

    mau_pkg::t_cmd  cmd;
    mau_pkg::t_stat stat;

    mau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mau_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

[rtl/mau_checker.sv]
// Port-level checker for the modular arithmetic unit, with its bind.
`include "assert_macros.svh"

module mau_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  mau_pkg::t_out               i_out_data,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [mau_pkg::MOD_BITS-1:0] i_cfg_data
);

    mau_pkg::t_res r_mod;
    mau_pkg::t_res m_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mau_pkg::MOD_RESET;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_mod <= i_cfg_data;
        end
    end

    assign m_eff = (r_mod == '0) ? mau_pkg::t_res'(1) : r_mod;

    `MAU_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    `MAU_ASSERT_IMP(a_result_range, i_clk, i_rst_n, i_out_valid, i_out_data.result < m_eff)
    `MAU_ASSERT_IMP(a_no_inv_zero, i_clk, i_rst_n, i_out_valid && i_out_data.no_inverse, i_out_data.result == '0)
    `MAU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data))

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .i_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);
